>>> design/admd_pkg.sv
// ----------------------------------------------------------------------------
// admd_pkg
// Shared widths, register codes and inter-module control types for the
// audio downmix and rate converter.
// ----------------------------------------------------------------------------
package admd_pkg;

  // Fixed frame layout: one input lane per channel port.
  localparam int LANES         = 8;
  localparam int LANE_SUM_BITS = $clog2(LANES);

  // Register widths.
  localparam int CH_W       = 4;
  localparam int RATE_W     = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_TARGET_RATE  = 16000;
  localparam int DEF_SAMPLE_BITS  = 16;

  // Register values after reset.
  localparam logic [CH_W-1:0]   RESET_CHANNEL_COUNT = 4'd1;
  localparam logic [RATE_W-1:0] RESET_SOURCE_RATE   = 18'd16000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_SOURCE_RATE   = 2'd1
  } cfg_reg_t;

  // Per-lane capture control.
  typedef struct packed {
    logic load;
    logic enable;
  } admd_lane_ctl_t;

  // Request to the merge and divide stage.
  typedef struct packed {
    logic            start;
    logic [CH_W-1:0] divisor;
  } admd_div_req_t;

endpackage

>>> design/admd_lane.sv
// ----------------------------------------------------------------------------
// admd_lane
// One channel lane: captures its sample when the item is taken, or zero
// when the channel is not in use.
// ----------------------------------------------------------------------------
module admd_lane
  import admd_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  admd_lane_ctl_t                ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SAMPLE_BITS-1:0] value
);

  logic signed [SAMPLE_BITS-1:0] value_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value_r <= ctl.enable ? sample : '0;
    end
  end

  assign value = value_r;

endmodule

>>> design/admd_merge_div.sv
// ----------------------------------------------------------------------------
// admd_merge_div
// Adds the lane values and divides the sum by the channel count, truncating
// toward zero. The division is restoring, eight quotient bits a cycle.
// ----------------------------------------------------------------------------
module admd_merge_div
  import admd_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  admd_div_req_t                 req,
  input  logic signed [SAMPLE_BITS-1:0] lane_value [LANES],
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] mono
);

  localparam int SumW      = SAMPLE_BITS + LANE_SUM_BITS;
  localparam int DigW      = 8;
  localparam int DivCycles = (SumW + DigW - 1) / DigW;
  localparam int PadW      = DivCycles * DigW;
  localparam int CntW      = $clog2(DivCycles + 1);

  logic signed [SumW-1:0]        sum;
  logic [SumW-1:0]               mag;
  logic [PadW-1:0]               dvd_r;
  logic [PadW-1:0]               quo_r;
  logic [PadW-1:0]               quo_nxt;
  logic [PadW-1:0]               quo_signed;
  logic [CH_W-1:0]               rem_r;
  logic [CH_W-1:0]               rem_nxt;
  logic [CH_W-1:0]               div_r;
  logic [CntW-1:0]               cnt_r;
  logic                          neg_r;
  logic                          busy_r;
  logic                          done_r;
  logic signed [SAMPLE_BITS-1:0] mono_r;
  logic [DigW-1:0]               qbits;
  logic [CH_W:0]                 trial;

  // Merge: the disabled lanes hold zero.
  always_comb begin
    sum = '0;
    for (int i = 0; i < LANES; i++) begin
      sum = sum + SumW'(lane_value[i]);
    end
    mag = sum[SumW-1] ? SumW'(-sum) : SumW'(sum);
  end

  // One digit of eight quotient bits; the remainder stays below the divisor.
  always_comb begin
    rem_nxt = rem_r;
    qbits   = '0;
    trial   = '0;
    for (int k = 0; k < DigW; k++) begin
      trial = {rem_nxt, dvd_r[PadW-1-k]};
      if (trial >= {1'b0, div_r}) begin
        qbits[DigW-1-k] = 1'b1;
        rem_nxt         = CH_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[CH_W-1:0];
      end
    end
    quo_nxt    = {quo_r[PadW-DigW-1:0], qbits};
    quo_signed = neg_r ? PadW'(-quo_nxt) : quo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(DivCycles);
        dvd_r  <= PadW'(mag);
        quo_r  <= '0;
        rem_r  <= '0;
        neg_r  <= sum[SumW-1];
        div_r  <= req.divisor;
      end else if (busy_r) begin
        dvd_r <= dvd_r << DigW;
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          mono_r <= quo_signed[SAMPLE_BITS-1:0];
        end
      end
    end
  end

  assign done = done_r;
  assign mono = mono_r;

endmodule

>>> design/audio_downmix_rate_converter.sv
// ----------------------------------------------------------------------------
// audio_downmix_rate_converter
// Averages the channels in use of a multichannel frame into one mono sample
// and resamples to a fixed target rate by nearest-neighbour repetition.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   in_       into block in_valid / in_stall   in_sample_ch0..7, in_end_of_buffer
//   out_      out        out_valid / out_stall out_mono_sample, out_last_of_run
//   cfg_      into block cfg_valid / cfg_ready cfg_index, cfg_data
//
// An item causes n results, where n is 0 to 4. The next item is taken only
// once the block is idle again: after the serial divider has finished and
// every result of the item has entered the single output register, which
// takes one result a cycle while the output is not stalled. The serial
// divider and that output register set the spacing of items.
// Reset is synchronous and active low; it restores the register defaults
// and clears the phase accumulator. A stalled output holds its result; the
// next result waits, and the next item may be taken while the last result
// of the previous one still waits.
//
module audio_downmix_rate_converter
  import admd_pkg::*;
#(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int TARGET_RATE  = DEF_TARGET_RATE,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Frame channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch0,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch1,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch2,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch3,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch4,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch5,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch6,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch7,
  input  logic                          in_end_of_buffer,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_mono_sample,
  output logic                          out_last_of_run,
  // Configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  // The accumulator holds the phase plus one target step before any
  // subtraction, which needs one bit over the rate register.
  localparam int AccW    = RATE_W + 1;
  localparam int MinRate = (TARGET_RATE + 3) / 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t                        state_r;
  logic [CH_W-1:0]               chan_count_r;
  logic [RATE_W-1:0]             src_rate_r;
  logic [RATE_W-1:0]             phase_r;
  logic [AccW-1:0]               acc_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_mono_r;
  logic                          out_last_r;

  logic [CH_W-1:0]               chans_eff;
  logic [RATE_W-1:0]             rate_eff;
  logic [AccW-1:0]               rate_ext;
  logic [AccW-1:0]               acc_diff;
  logic                          in_accept;
  logic                          slot_free;
  logic                          last_one;
  logic                          div_done;
  logic signed [SAMPLE_BITS-1:0] div_mono;
  admd_div_req_t                 div_req;
  admd_lane_ctl_t                lane_ctl [LANES];
  logic signed [SAMPLE_BITS-1:0] lane_in  [LANES];
  logic signed [SAMPLE_BITS-1:0] lane_val [LANES];

  // Effective register values: a zero channel count means one channel and
  // the count saturates at the parameter; a zero rate means the target rate,
  // and the rate is held at the bound that keeps a frame to four results.
  always_comb begin
    chans_eff = chan_count_r;
    if (chans_eff == '0) begin
      chans_eff = CH_W'(1);
    end else if (chans_eff > CH_W'(MAX_CHANNELS)) begin
      chans_eff = CH_W'(MAX_CHANNELS);
    end
    rate_eff = src_rate_r;
    if (rate_eff == '0) begin
      rate_eff = RATE_W'(TARGET_RATE);
    end
    if (rate_eff < RATE_W'(MinRate)) begin
      rate_eff = RATE_W'(MinRate);
    end
  end

  assign rate_ext  = AccW'(rate_eff);
  assign acc_diff  = acc_r - rate_ext;
  assign last_one  = acc_diff < rate_ext;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Always ready; the user must see the block is only written idle; not enforced.
  assign cfg_ready = 1'b1;

  // The end-of-buffer flag travels with the frame but has no bearing on the
  // results, so it is not stored.

  assign lane_in[0] = in_sample_ch0;
  assign lane_in[1] = in_sample_ch1;
  assign lane_in[2] = in_sample_ch2;
  assign lane_in[3] = in_sample_ch3;
  assign lane_in[4] = in_sample_ch4;
  assign lane_in[5] = in_sample_ch5;
  assign lane_in[6] = in_sample_ch6;
  assign lane_in[7] = in_sample_ch7;

  // Channel lanes: each captures its sample when the frame is taken, or
  // zero when its channel lies beyond the effective count.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign lane_ctl[i].load   = in_accept;
    assign lane_ctl[i].enable = (CH_W'(i) < chans_eff);

    admd_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk    (clk),
      .ctl    (lane_ctl[i]),
      .sample (lane_in[i]),
      .value  (lane_val[i])
    );
  end

  assign div_req.start   = (state_r == ST_START);
  assign div_req.divisor = chans_eff;

  // Merging stage: sum of the lanes, then the truncating division.
  admd_merge_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (div_req),
    .lane_value (lane_val),
    .done       (div_done),
    .mono       (div_mono)
  );

  // Sequencer, configuration registers, phase accumulator and the output
  // register. One result leaves per cycle while the output can take it; the
  // result that brings the accumulator below the rate is the last of the
  // frame, and its remainder becomes the new phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      chan_count_r <= RESET_CHANNEL_COUNT;
      src_rate_r   <= RESET_SOURCE_RATE;
      phase_r      <= '0;
      acc_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CHANNEL_COUNT: begin
            chan_count_r <= cfg_data[CH_W-1:0];
            phase_r      <= '0;
          end
          CFG_SOURCE_RATE: begin
            src_rate_r <= cfg_data[RATE_W-1:0];
            phase_r    <= '0;
          end
          default: begin
            // Unknown index: the write is dropped.
          end
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            acc_r   <= AccW'(phase_r) + AccW'(TARGET_RATE);
            state_r <= ST_START;
          end
        end
        ST_START: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (acc_r < rate_ext) begin
            // The frame gives no result.
            phase_r <= acc_r[RATE_W-1:0];
            state_r <= ST_IDLE;
          end else if (slot_free) begin
            out_valid_r <= 1'b1;
            out_mono_r  <= div_mono;
            out_last_r  <= last_one;
            acc_r       <= acc_diff;
            if (last_one) begin
              phase_r <= acc_diff[RATE_W-1:0];
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mono_sample = out_mono_r;
  assign out_last_of_run = out_last_r;

endmodule
